// ===== sv/i2cras_pkg.sv =====
package i2cras_pkg;

	localparam int MAX_BYTES = 4;
	localparam int IDX_W     = 3;
	localparam int BUF_IDX_W = 2;
	localparam int CFG_IDX_W = 3;
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 48;

	typedef enum logic [1:0] {
		REQ_START = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_READ  = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		ACT_NONE = 3'd0,
		ACT_ADDR = 3'd1,
		ACT_BYTE = 3'd2,
		ACT_STOP = 3'd3,
		ACT_ACK  = 3'd4,
		ACT_NACK = 3'd5
	} action_t;

	typedef enum logic [2:0] {
		ST_BUSY      = 3'd0,
		ST_DONE      = 3'd1,
		ST_REG_NACK  = 3'd2,
		ST_ADDR_NACK = 3'd3,
		ST_ARB_LOST  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		PH_ADDR = 2'd0,
		PH_REG  = 2'd1,
		PH_READ = 2'd2
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SLAVE_ADDR = 3'd0,
		CFG_REG_ADDR   = 3'd1,
		CFG_BYTE_COUNT = 3'd2,
		CFG_WRITE_MODE = 3'd3,
		CFG_WRITE_DATA = 3'd4
	} cfg_idx_t;

endpackage

// ===== sv/i2c_register_access_sequencer_core.sv =====
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser req_type, tdata event fields
// m_axis    out        m_axis_tvalid / m_axis_tready  tuser action, tdata byte/status/read
// cfg       in         cfg_valid / cfg_ready          cfg_index, cfg_data
//
// One result per event, held in a registered output; a new event is taken every cycle
// while the result register is empty or being drained.
// The result register is the only stage; s_axis_tready drops only while a
// result waits and m_axis_tready is low.
// arst_n clears phase, byte index, status, read buffer, registers and output valid.
// cfg_ready is always high.
module i2c_register_access_sequencer_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [0] clock_hold, [1] rx_nack, [9:2] rx_data, rest zero
	input  logic [i2cras_pkg::S_TDATA_W-1:0]    s_axis_tdata,
	// [1:0] req_type
	input  logic [1:0]                          s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [7:0] out_byte, [10:8] status, [42:11] read_data, rest zero
	output logic [i2cras_pkg::M_TDATA_W-1:0]    m_axis_tdata,
	// [2:0] action
	output logic [2:0]                          m_axis_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [i2cras_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                         cfg_data
);
	import i2cras_pkg::*;

	logic [6:0]            slave_addr_q;
	logic [7:0]            reg_addr_q;
	logic [2:0]            byte_count_q;
	logic                  write_mode_q;
	logic [31:0]           write_data_q;

	phase_t                phase_q, phase_d;
	logic [IDX_W-1:0]      byte_idx_q, byte_idx_d;
	status_t               result_q, result_d;
	logic [7:0]            rbuf_q [MAX_BYTES];
	logic [7:0]            rbuf_d [MAX_BYTES];

	logic                  out_valid_q;
	action_t               action_q;
	logic [7:0]            out_byte_q;
	status_t               status_q;
	logic [31:0]           read_data_q;

	logic                  s_xfer;
	req_t                  req;
	logic                  hold, nack;
	logic [7:0]            rx_data;
	logic [IDX_W-1:0]      count;
	logic [IDX_W-1:0]      idx_inc;
	logic                  active, ev_addr, ev_reg, ev_read;
	action_t               action_d;
	logic [7:0]            out_byte_d;
	logic [31:0]           read_data_d;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign s_xfer        = s_axis_tvalid && s_axis_tready;

	assign req     = req_t'(s_axis_tuser);
	assign hold    = s_axis_tdata[0];
	assign nack    = s_axis_tdata[1];
	assign rx_data = s_axis_tdata[9:2];

	assign count   = (byte_count_q > IDX_W'(MAX_BYTES)) ? IDX_W'(MAX_BYTES) : byte_count_q;
	assign idx_inc = byte_idx_q + IDX_W'(1);

	assign active  = (result_q == ST_BUSY);
	assign ev_addr = active && (req == REQ_WRITE) && (phase_q == PH_ADDR);
	assign ev_reg  = active && (req == REQ_WRITE) && (phase_q == PH_REG);
	assign ev_read = active && (req == REQ_READ) && (phase_q == PH_READ) && hold;

	// next state
	always_comb begin
		phase_d    = phase_q;
		byte_idx_d = byte_idx_q;
		result_d   = result_q;
		rbuf_d     = rbuf_q;
		priority if (req == REQ_START) begin
			phase_d    = PH_ADDR;
			byte_idx_d = '0;
			result_d   = ST_BUSY;
			for (int i = 0; i < MAX_BYTES; i++) rbuf_d[i] = '0;
		end else if (ev_addr) begin
			if (hold && !nack) phase_d = PH_REG;
			else if (hold) result_d = ST_ADDR_NACK;
			else result_d = ST_ARB_LOST;
		end else if (ev_reg) begin
			if (nack) result_d = ST_REG_NACK;
			else if (!write_mode_q) phase_d = PH_READ;
			else if (byte_idx_q >= count) result_d = ST_DONE;
			else byte_idx_d = idx_inc;
		end else if (ev_read) begin
			if (byte_idx_q < IDX_W'(MAX_BYTES))
				rbuf_d[byte_idx_q[BUF_IDX_W-1:0]] = rx_data;
			byte_idx_d = idx_inc;
			if (idx_inc >= count) result_d = ST_DONE;
		end else begin
			phase_d = phase_q;
		end
	end

	// result fields
	always_comb begin
		action_d   = ACT_NONE;
		out_byte_d = '0;
		priority if (req == REQ_START) begin
			action_d   = ACT_ADDR;
			out_byte_d = {slave_addr_q, 1'b0};
		end else if (ev_addr) begin
			if (hold && !nack) begin
				action_d   = ACT_BYTE;
				out_byte_d = reg_addr_q;
			end else if (hold) begin
				action_d = ACT_STOP;
			end
		end else if (ev_reg) begin
			if (nack) begin
				action_d = ACT_STOP;
			end else if (!write_mode_q) begin
				action_d   = ACT_ADDR;
				out_byte_d = {slave_addr_q, 1'b1};
			end else if (byte_idx_q >= count) begin
				action_d = ACT_STOP;
			end else begin
				action_d   = ACT_BYTE;
				out_byte_d = write_data_q[8*byte_idx_q[BUF_IDX_W-1:0] +: 8];
			end
		end else if (ev_read) begin
			action_d = (idx_inc >= count) ? ACT_NACK : ACT_ACK;
		end else begin
			action_d = ACT_NONE;
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) read_data_d[8*i +: 8] = rbuf_d[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= '0;
			reg_addr_q   <= '0;
			byte_count_q <= '0;
			write_mode_q <= 1'b0;
			write_data_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SLAVE_ADDR: slave_addr_q <= cfg_data[6:0];
				CFG_REG_ADDR:   reg_addr_q   <= cfg_data[7:0];
				CFG_BYTE_COUNT: byte_count_q <= cfg_data[2:0];
				CFG_WRITE_MODE: write_mode_q <= cfg_data[0];
				CFG_WRITE_DATA: write_data_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_ADDR;
			byte_idx_q <= '0;
			result_q   <= ST_BUSY;
			for (int i = 0; i < MAX_BYTES; i++) rbuf_q[i] <= '0;
		end else if (s_xfer) begin
			phase_q    <= phase_d;
			byte_idx_q <= byte_idx_d;
			result_q   <= result_d;
			rbuf_q     <= rbuf_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_xfer) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			action_q    <= action_d;
			out_byte_q  <= out_byte_d;
			status_q    <= result_d;
			read_data_q <= read_data_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = action_q;
	assign m_axis_tdata  = {5'd0, read_data_q, status_q, out_byte_q};

endmodule

// ===== dv/tb.sv =====
module tb;
	import i2cras_pkg::*;

	// request code with no meaning; the block must ignore it
	localparam logic [1:0] REQ_SPARE = 2'd3;
	// register index with no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
	localparam bit MODE_READ  = 1'b0;
	localparam bit MODE_WRITE = 1'b1;

	typedef struct packed {
		action_t     act;
		logic [7:0]  obyte;
		status_t     st;
		logic [31:0] rdata;
	} bus_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
	logic [1:0]             s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_axis_tdata;
	logic [2:0]             m_axis_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [31:0]            cfg_data = '0;

	i2c_register_access_sequencer_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #10 clk = ~clk;

	// register copies
	logic [6:0]  cfg_slave;
	logic [7:0]  cfg_reg;
	logic [2:0]  cfg_count;
	logic        cfg_wmode;
	logic [31:0] cfg_wdata;

	// sequencer state
	phase_t      seq_phase;
	logic [2:0]  seq_idx;
	status_t     seq_status;
	logic [7:0]  rx_buf [0:MAX_BYTES-1];

	bus_result_t exp_results[$];
	int          sent_events = 0;
	int          fail_count = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		case (idx)
			CFG_SLAVE_ADDR: cfg_slave = data[6:0];
			CFG_REG_ADDR:   cfg_reg   = data[7:0];
			CFG_BYTE_COUNT: cfg_count = data[2:0];
			CFG_WRITE_MODE: cfg_wmode = data[0];
			CFG_WRITE_DATA: cfg_wdata = data;
			default: ;
		endcase
	endfunction

	function automatic bus_result_t step_sequencer(logic [1:0] req, logic hold, logic nack,
			logic [7:0] rx);
		bus_result_t r;
		logic [2:0]  lim;
		lim = (cfg_count > MAX_BYTES) ? 3'(MAX_BYTES) : cfg_count;
		r.act = ACT_NONE;
		r.obyte = 8'h00;
		if (req == REQ_START) begin
			seq_phase = PH_ADDR;
			seq_idx = '0;
			seq_status = ST_BUSY;
			for (int i = 0; i < MAX_BYTES; i++)
				rx_buf[i] = 8'h00;
			r.act = ACT_ADDR;
			r.obyte = {cfg_slave, 1'b0};
		end else if (seq_status == ST_BUSY) begin
			if (req == REQ_WRITE && seq_phase == PH_ADDR) begin
				if (hold && !nack) begin
					r.act = ACT_BYTE;
					r.obyte = cfg_reg;
					seq_phase = PH_REG;
				end else if (hold) begin
					r.act = ACT_STOP;
					seq_status = ST_ADDR_NACK;
				end else begin
					seq_status = ST_ARB_LOST;
				end
			end else if (req == REQ_WRITE && seq_phase == PH_REG) begin
				// clock_hold is not looked at in the register phase
				if (nack) begin
					r.act = ACT_STOP;
					seq_status = ST_REG_NACK;
				end else if (cfg_wmode == MODE_READ) begin
					r.act = ACT_ADDR;
					r.obyte = {cfg_slave, 1'b1};
					seq_phase = PH_READ;
				end else if (seq_idx >= lim) begin
					r.act = ACT_STOP;
					seq_status = ST_DONE;
				end else begin
					r.act = ACT_BYTE;
					r.obyte = (seq_idx < 4) ? cfg_wdata[8*seq_idx +: 8] : 8'h00;
					seq_idx++;
				end
			end else if (req == REQ_READ && seq_phase == PH_READ && hold) begin
				if (seq_idx < MAX_BYTES)
					rx_buf[seq_idx] = rx;
				seq_idx++;
				// a count of zero still takes one byte
				if (seq_idx >= lim) begin
					r.act = ACT_NACK;
					seq_status = ST_DONE;
				end else begin
					r.act = ACT_ACK;
				end
			end
		end
		r.st = seq_status;
		r.rdata = {rx_buf[3], rx_buf[2], rx_buf[1], rx_buf[0]};
		return r;
	endfunction

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		bus_result_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (exp_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: act %0d tdata %h", m_axis_tuser, m_axis_tdata);
			end else begin
				want = exp_results.pop_front();
				if (m_axis_tuser !== want.act || m_axis_tdata[7:0] !== want.obyte ||
						m_axis_tdata[10:8] !== want.st || m_axis_tdata[42:11] !== want.rdata ||
						m_axis_tdata[M_TDATA_W-1:43] !== '0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: act %0d/%0d byte %h/%h status %0d/%0d read %h/%h pad %h",
							want.act, m_axis_tuser, want.obyte, m_axis_tdata[7:0],
							want.st, m_axis_tdata[10:8], want.rdata, m_axis_tdata[42:11],
							m_axis_tdata[M_TDATA_W-1:43]);
				end
			end
		end
	end

	task automatic send_event(logic [1:0] req, logic hold, logic nack, logic [7:0] rx);
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= req;
		s_axis_tdata <= {6'b0, rx, nack, hold};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		exp_results.push_back(step_sequencer(req, hold, nack, rx));
		sent_events++;
	endtask

	// hold the sender off until every outstanding result has been taken
	task automatic settle_bus();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (exp_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(logic [6:0] slave, logic [7:0] regi, logic [2:0] count,
			logic wmode, logic [31:0] wdata);
		settle_bus();
		set_reg(CFG_SLAVE_ADDR, {25'($urandom), slave});
		set_reg(CFG_REG_ADDR, {24'($urandom), regi});
		set_reg(CFG_BYTE_COUNT, {29'($urandom), count});
		set_reg(CFG_WRITE_MODE, {31'($urandom), wmode});
		set_reg(CFG_WRITE_DATA, wdata);
	endtask

	task automatic reconfigure_random();
		int pick;
		settle_bus();
		pick = $urandom_range(2);
		if ($urandom_range(1))
			set_reg(CFG_SLAVE_ADDR, pick == 0 ? 32'h0 : pick == 1 ? 32'h7F : $urandom);
		pick = $urandom_range(2);
		if ($urandom_range(1))
			set_reg(CFG_REG_ADDR, pick == 0 ? 32'h0 : pick == 1 ? 32'hFF : $urandom);
		if ($urandom_range(1))
			set_reg(CFG_BYTE_COUNT, $urandom);
		if ($urandom_range(1))
			set_reg(CFG_WRITE_MODE, $urandom);
		pick = $urandom_range(3);
		if ($urandom_range(1))
			set_reg(CFG_WRITE_DATA, pick == 0 ? 32'h0 : pick == 1 ? 32'hFFFF_FFFF : $urandom);
		if ($urandom_range(9) == 0)
			set_reg(3'($urandom_range(5, 7)), $urandom);
	endtask

	task automatic send_noise();
		send_event(2'($urandom_range(3)), 1'($urandom), 1'($urandom), 8'($urandom));
	endtask

	// one register access with random content, sometimes cut short or salted with noise
	task automatic run_transfer();
		logic [2:0] lim;
		int         total;
		int         stop_at;
		int         roll;
		lim = (cfg_count > MAX_BYTES) ? 3'(MAX_BYTES) : cfg_count;
		if (cfg_wmode == MODE_WRITE)
			total = 3 + lim;
		else
			total = 3 + ((lim == 0) ? 1 : lim);
		stop_at = ($urandom_range(99) < 10) ? $urandom_range(1, total - 1) : total;
		for (int step = 0; step < stop_at; step++) begin
			if ($urandom_range(99) < 8)
				send_noise();
			roll = $urandom_range(99);
			if (step == 0)
				send_event(REQ_START, 1'($urandom), 1'($urandom), 8'($urandom));
			else if (step == 1)
				send_event(REQ_WRITE, roll >= 6, roll >= 6 && roll < 12, 8'($urandom));
			else if (step == 2 || cfg_wmode == MODE_WRITE)
				send_event(REQ_WRITE, 1'($urandom), roll < 5, 8'($urandom));
			else
				send_event(REQ_READ, roll >= 5, 1'($urandom), 8'($urandom));
		end
	endtask

	task automatic test_directed();
		configure(7'h7F, 8'hFF, 3'd2, MODE_WRITE, 32'hFFFF_FFFF);
		send_event(REQ_START, 1'b0, 1'b0, 8'h00);
		send_event(REQ_WRITE, 1'b1, 1'b0, 8'hFF);
		send_event(REQ_READ, 1'b1, 1'b1, 8'hFF);   // read outside data phase
		send_event(REQ_SPARE, 1'b1, 1'b0, 8'h00);
		send_event(REQ_WRITE, 1'b1, 1'b0, 8'h00);
		send_event(REQ_WRITE, 1'b1, 1'b0, 8'h00);
		send_event(REQ_WRITE, 1'b1, 1'b0, 8'h00);  // all sent: stop, no extra byte

		// count above the buffer size saturates
		configure(7'h00, 8'h00, 3'd7, MODE_READ, 32'h0);
		send_event(REQ_START, 1'b1, 1'b1, 8'hFF);
		send_event(REQ_WRITE, 1'b1, 1'b0, 8'h00);
		send_event(REQ_WRITE, 1'b0, 1'b0, 8'h00);
		send_event(REQ_READ, 1'b1, 1'b0, 8'hFF);
		send_event(REQ_READ, 1'b1, 1'b0, 8'h00);
		send_event(REQ_READ, 1'b1, 1'b0, 8'hA5);
		send_event(REQ_READ, 1'b1, 1'b0, 8'h5A);

		settle_bus();
		set_reg(CFG_SPARE, 32'hFFFF_FFFF);
		set_reg(CFG_BYTE_COUNT, 32'h0);
		send_event(REQ_START, 1'b0, 1'b0, 8'h00);
		send_event(REQ_WRITE, 1'b1, 1'b0, 8'h00);
		send_event(REQ_WRITE, 1'b1, 1'b0, 8'h00);
		send_event(REQ_WRITE, 1'b1, 1'b0, 8'h11);  // write event in read phase
		send_event(REQ_READ, 1'b0, 1'b0, 8'h22);   // no clock hold
		send_event(REQ_READ, 1'b1, 1'b0, 8'h3C);   // zero count: one byte then done

		send_event(REQ_START, 1'b0, 1'b0, 8'h00);
		send_event(REQ_WRITE, 1'b0, 1'b0, 8'h00);  // arbitration lost
		send_event(REQ_WRITE, 1'b1, 1'b0, 8'h00);  // finished, ignored
		send_event(REQ_START, 1'b0, 1'b0, 8'h00);
		send_event(REQ_WRITE, 1'b1, 1'b1, 8'h00);  // address NACK
	endtask

	task automatic test_random(int send_pct, int recv_pct, int n_events);
		int base;
		settle_bus();
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		base = sent_events;
		while (sent_events - base < n_events) begin
			if ($urandom_range(99) < 30)
				reconfigure_random();
			run_transfer();
		end
	endtask

	initial begin
		apply_reg(CFG_SLAVE_ADDR, 32'h0);
		apply_reg(CFG_REG_ADDR, 32'h0);
		apply_reg(CFG_BYTE_COUNT, 32'h0);
		apply_reg(CFG_WRITE_MODE, 32'h0);
		apply_reg(CFG_WRITE_DATA, 32'h0);
		seq_phase = PH_ADDR;
		seq_idx = '0;
		seq_status = ST_BUSY;
		for (int i = 0; i < MAX_BYTES; i++)
			rx_buf[i] = 8'h00;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random(0, 0, 95);
		test_random(70, 0, 95);
		test_random(0, 70, 95);
		test_random(35, 35, 95);

		settle_bus();
		repeat (4) @(posedge clk);
		fail_count += exp_results.size();
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
